// ===== sv/lookahead_peak_limiter_unit_assert.svh =====
// ---------------------------------------------------------------------------
// lookahead_peak_limiter_unit_assert.svh
// Assertion macros for the peak limiter. They expect clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef LOOKAHEAD_PEAK_LIMITER_UNIT_ASSERT_SVH
`define LOOKAHEAD_PEAK_LIMITER_UNIT_ASSERT_SVH

// same-cycle implication
`define LPL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpl: same-cycle check failed");

// next-cycle implication
`define LPL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpl: next-cycle check failed");

`endif

// ===== sv/lpl_pkg.sv =====
// ---------------------------------------------------------------------------
// lpl_pkg
// Widths, constants and shared types of the lookahead peak limiter.
// ---------------------------------------------------------------------------
package lpl_pkg;

  localparam int SMP_W             = 24;   // Q1.23 sample / gain width
  localparam int FRAC              = 23;   // fraction bits
  localparam int LOOK_W            = 9;    // lookahead register width
  localparam int QUO_W             = FRAC; // target gain fraction bits
  localparam int MAX_LOOKAHEAD_DEF = 512;
  localparam int APB_DW            = 32;
  localparam int APB_AW            = 5;

  localparam logic [SMP_W-1:0] UNITY = 24'h800000;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_CEILING = 3'd0;
  localparam logic [2:0] REG_LOOK    = 3'd1;
  localparam logic [2:0] REG_ATTACK  = 3'd2;
  localparam logic [2:0] REG_RELEASE = 3'd3;
  localparam logic [2:0] REG_BYPASS  = 3'd4;

  // request to the divider: dividend must be below divisor
  typedef struct packed {
    logic             start;
    logic [SMP_W-1:0] dividend;
    logic [SMP_W-1:0] divisor;
  } div_req_t;

endpackage

// ===== sv/lpl_div.sv =====
// ---------------------------------------------------------------------------
// lpl_div
// Radix-2 restoring fraction divider: floor(dividend * 2^23 / divisor),
// one quotient bit per cycle; the done flag is registered after the last bit.
// ---------------------------------------------------------------------------
module lpl_div
  import lpl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  localparam int CNT_W = $clog2(QUO_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SMP_W-1:0] rem_r;
  logic [SMP_W-1:0] dvs_r;
  logic [QUO_W-1:0] quo_r;

  logic [SMP_W:0]   rem_sh;
  logic             ge;
  logic             last;

  assign rem_sh = {rem_r, 1'b0};
  assign ge     = rem_sh >= {1'b0, dvs_r};
  assign last   = cnt_r == CNT_W'(QUO_W - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend;
      dvs_r <= req.divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? SMP_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[SMP_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== sv/lookahead_peak_limiter_unit.sv =====
// ---------------------------------------------------------------------------
// lookahead_peak_limiter_unit
// Stereo lookahead peak limiter, one stereo frame per request.
// in_*  : stream slave. in_tdata = {right_in, left_in}, in_tuser = mono_input.
// out_* : stream master. out_tdata = {right_out, left_out}. One result per
//         input request, in order.
// cfg   : APB write/read, pready tied high. Registers at 4*i: ceiling,
//         lookahead, attack, release, bypass. Write only while idle.
// Flow: in_tready is high only in the idle state. A limited frame runs
//   through S_PEAK, S_DIV while the divider works if the peak is above the
//   ceiling, S_M1 to S_M6 and S_OUT; a bypassed frame goes from idle straight
//   to S_OUT. in_tready returns high together with out_tvalid. One 25x25 signed
//   multiplier serves all four multiplies of a frame.
// Stall: the result waits in the output register; the next request is
//   accepted meanwhile, and its result waits in the sequencer until the
//   output register is free.
// Reset: synchronous, active low. Envelope returns to unity, write pointer
//   and fill count to zero; delay entries not written since reset read as
//   zero through the fill count, so no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "lookahead_peak_limiter_unit_assert.svh"

module lookahead_peak_limiter_unit
  import lpl_pkg::*;
#(
  parameter int MAX_LOOKAHEAD = MAX_LOOKAHEAD_DEF
)
(
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,   // [23:0] left_in, [47:24] right_in
  input  logic              in_tuser,   // [0] mono_input
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,  // [23:0] left_out, [47:24] right_out
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW     = $clog2(MAX_LOOKAHEAD);
  localparam int LW     = (AW > LOOK_W) ? AW : LOOK_W;
  localparam int MUL_W  = SMP_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int Q_W    = PROD_W - FRAC;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRAC - 1);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_PEAK = 10'b0000000010,
    S_DIV  = 10'b0000000100,
    S_M1   = 10'b0000001000,
    S_M2   = 10'b0000010000,
    S_M3   = 10'b0000100000,
    S_M4   = 10'b0001000000,
    S_M5   = 10'b0010000000,
    S_M6   = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  // round half up, floor by 2^23, clamp to +-ceiling
  function automatic logic signed [SMP_W-1:0] gain_clamp(
    input logic signed [PROD_W-1:0] p,
    input logic [SMP_W-1:0]         c
  );
    logic signed [PROD_W-1:0] s;
    logic signed [Q_W-1:0]    q;
    logic signed [Q_W-1:0]    cp;
    logic signed [Q_W-1:0]    r;
    s  = p + HALF;
    q  = s[PROD_W-1:FRAC];
    cp = signed'(Q_W'(c));
    if (q > cp) begin
      r = cp;
    end else if (q < -cp) begin
      r = -cp;
    end else begin
      r = q;
    end
    return r[SMP_W-1:0];
  endfunction

  // configuration registers
  logic [SMP_W-1:0]  ceil_r, att_r, rel_r;
  logic [LOOK_W-1:0] look_r;
  logic              byp_r;

  // sequencer and state
  state_t            state_r, state_nxt;
  logic [SMP_W-1:0]  env_r, env_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [AW:0]       fill_r, fill_nxt;
  logic              out_valid_r, out_valid_nxt;

  // datapath payload
  logic signed [SMP_W-1:0]  smp_l_r, smp_l_nxt, smp_r_r, smp_r_nxt;
  logic signed [SMP_W-1:0]  res_l_r, res_l_nxt, res_r_r, res_r_nxt;
  logic [SMP_W-1:0]         target_r, target_nxt;
  logic signed [PROD_W-1:0] acc_r, acc_nxt, prod_r, prod_nxt;
  logic [AW-1:0]            rd_addr_r, rd_addr_nxt;
  logic                     hit_r, hit_nxt;
  logic [47:0]              out_data_r, out_data_nxt;

  // delay line
  logic [2*SMP_W-1:0] dl_mem_r [MAX_LOOKAHEAD];
  logic [2*SMP_W-1:0] rd_q_r;

  // helpers
  logic                     in_acc, cfg_wr;
  logic [2:0]               cfg_idx;
  logic [SMP_W-1:0]         ceil_sat, coef, abs_l, abs_r, peak;
  logic signed [SMP_W-1:0]  in_l, in_r, dl_l, dl_r;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic [AW-1:0]            look_c;
  logic [AW:0]              rd_sum;
  logic [AW:0]              fill_inc;
  logic signed [PROD_W-1:0] blend;
  logic [SMP_W:0]           env_cand;
  div_req_t                 div_req;
  logic                     div_done;
  logic [QUO_W-1:0]         div_quo;

  assign in_acc  = in_tvalid && in_tready;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  assign in_l = signed'(in_tdata[SMP_W-1:0]);
  assign in_r = in_tuser ? in_l : signed'(in_tdata[2*SMP_W-1:SMP_W]);

  assign ceil_sat = (ceil_r > UNITY) ? UNITY : ceil_r;
  // attack when the target falls below the running envelope
  assign coef     = (target_r < env_r) ? ((att_r > UNITY) ? UNITY : att_r)
                                       : ((rel_r > UNITY) ? UNITY : rel_r);

  assign abs_l = smp_l_r[SMP_W-1] ? SMP_W'(-smp_l_r) : smp_l_r;
  assign abs_r = smp_r_r[SMP_W-1] ? SMP_W'(-smp_r_r) : smp_r_r;
  assign peak  = (abs_r > abs_l) ? abs_r : abs_l;

  // read address = write pointer - lookahead, modulo the depth
  assign look_c = (LW'(look_r) > LW'(MAX_LOOKAHEAD - 1)) ? AW'(MAX_LOOKAHEAD - 1)
                                                         : AW'(look_r);
  assign rd_sum = (wp_r >= look_c) ? ((AW+1)'(wp_r) - (AW+1)'(look_c))
                                   : ((AW+1)'(wp_r) + (AW+1)'(MAX_LOOKAHEAD)
                                      - (AW+1)'(look_c));
  assign fill_inc = (fill_r == (AW+1)'(MAX_LOOKAHEAD)) ? fill_r : fill_r + 1'b1;

  // entries beyond the fill count were never written: they read as zero
  assign dl_l = hit_r ? signed'(rd_q_r[SMP_W-1:0]) : '0;
  assign dl_r = hit_r ? signed'(rd_q_r[2*SMP_W-1:SMP_W]) : '0;

  // shared multiplier
  always_comb begin
    case (state_r)
      S_M1: begin
        mul_a = signed'({1'b0, coef});
        mul_b = signed'({1'b0, env_r});
      end
      S_M2: begin
        mul_a = signed'({1'b0, SMP_W'(UNITY - coef)});
        mul_b = signed'({1'b0, target_r});
      end
      S_M4: begin
        mul_a = {dl_l[SMP_W-1], dl_l};
        mul_b = signed'({1'b0, env_r});
      end
      S_M5: begin
        mul_a = {dl_r[SMP_W-1], dl_r};
        mul_b = signed'({1'b0, env_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;
  assign blend    = acc_r + prod_r + HALF;
  assign env_cand = blend[FRAC+SMP_W:FRAC];

  assign div_req.start    = (state_r == S_PEAK) && (peak > ceil_sat);
  assign div_req.dividend = ceil_sat;
  assign div_req.divisor  = peak;

  lpl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    env_nxt       = env_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;
    smp_l_nxt     = smp_l_r;
    smp_r_nxt     = smp_r_r;
    res_l_nxt     = res_l_r;
    res_r_nxt     = res_r_r;
    target_nxt    = target_r;
    acc_nxt       = acc_r;
    rd_addr_nxt   = rd_addr_r;
    hit_nxt       = hit_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          smp_l_nxt = in_l;
          smp_r_nxt = in_r;
          if (byp_r) begin
            res_l_nxt = in_l;
            res_r_nxt = in_r;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_PEAK;
          end
        end
      end
      S_PEAK: begin
        // frame goes into the delay line this cycle
        rd_addr_nxt = rd_sum[AW-1:0];
        hit_nxt     = (AW+1)'(look_c) < fill_inc;
        fill_nxt    = fill_inc;
        wp_nxt      = (wp_r == AW'(MAX_LOOKAHEAD - 1)) ? '0 : wp_r + 1'b1;
        if (peak > ceil_sat) begin
          state_nxt = S_DIV;
        end else begin
          target_nxt = UNITY;
          state_nxt  = S_M1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          target_nxt = {1'b0, div_quo};
          state_nxt  = S_M1;
        end
      end
      S_M1: begin
        state_nxt = S_M2;
      end
      S_M2: begin
        acc_nxt   = prod_r;
        state_nxt = S_M3;
      end
      S_M3: begin
        env_nxt   = (env_cand > {1'b0, UNITY}) ? UNITY : env_cand[SMP_W-1:0];
        state_nxt = S_M4;
      end
      S_M4: begin
        state_nxt = S_M5;
      end
      S_M5: begin
        res_l_nxt = gain_clamp(prod_r, ceil_sat);
        state_nxt = S_M6;
      end
      S_M6: begin
        res_r_nxt = gain_clamp(prod_r, ceil_sat);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {res_r_r, res_l_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      env_r       <= UNITY;
      wp_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      ceil_r      <= UNITY;
      look_r      <= '0;
      att_r       <= '0;
      rel_r       <= 24'd8388000;
      byp_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      env_r       <= env_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_CEILING: ceil_r <= pwdata[SMP_W-1:0];
          REG_LOOK:    look_r <= pwdata[LOOK_W-1:0];
          REG_ATTACK:  att_r  <= pwdata[SMP_W-1:0];
          REG_RELEASE: rel_r  <= pwdata[SMP_W-1:0];
          REG_BYPASS:  byp_r  <= pwdata[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    smp_l_r    <= smp_l_nxt;
    smp_r_r    <= smp_r_nxt;
    res_l_r    <= res_l_nxt;
    res_r_r    <= res_r_nxt;
    target_r   <= target_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    rd_addr_r  <= rd_addr_nxt;
    hit_r      <= hit_nxt;
    out_data_r <= out_data_nxt;
  end

  // delay line: written in S_PEAK, read in S_M1, which follows S_PEAK or S_DIV
  always_ff @(posedge clk) begin
    if (state_r == S_PEAK) begin
      dl_mem_r[wp_r] <= {smp_r_r, smp_l_r};
    end
    if (state_r == S_M1) begin
      rd_q_r <= dl_mem_r[rd_addr_r];
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_CEILING: prdata = APB_DW'(ceil_r);
      REG_LOOK:    prdata = APB_DW'(look_r);
      REG_ATTACK:  prdata = APB_DW'(att_r);
      REG_RELEASE: prdata = APB_DW'(rel_r);
      REG_BYPASS:  prdata = APB_DW'(byp_r);
      default:     prdata = '0;
    endcase
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `LPL_ASSERT_IMP(a_env_unity, 1'b1, env_r <= UNITY)
  `LPL_ASSERT_IMP(a_fill_max, 1'b1, fill_r <= (AW+1)'(MAX_LOOKAHEAD))
  `LPL_ASSERT_IMP(a_div_done_state, div_done, state_r == S_DIV)
  `LPL_ASSERT_NXT(a_bypass_direct, in_acc && byp_r, state_r == S_OUT && env_r == $past(env_r))

endmodule

// ===== tb/lookahead_peak_limiter_unit_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lookahead_peak_limiter_unit_checker
// Watches the frame streams and the APB port of the peak limiter, predicts
// every frame, limited or bypassed, from the observed frames and register writes, and
// compares each result field with the oldest prediction still pending.
// ---------------------------------------------------------------------------
module lookahead_peak_limiter_unit_checker
  import lpl_pkg::*;
#(
  parameter int DEPTH = MAX_LOOKAHEAD_DEF
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [47:0]       in_tdata,   // [23:0] left_in, [47:24] right_in
  input  logic              in_tuser,   // [0] mono_input
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [47:0]       out_tdata,  // [23:0] left_out, [47:24] right_out
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int unsigned       mismatch_count,
  output int unsigned       frames_pending
);

  typedef struct packed {
    logic signed [SMP_W-1:0] right;
    logic signed [SMP_W-1:0] left;
  } stereo_t;

  localparam longint GAIN_ONE   = longint'(UNITY);
  localparam longint ROUND_HALF = GAIN_ONE / 2;

  // register copies
  logic [SMP_W-1:0]  ceiling_q;
  logic [LOOK_W-1:0] look_q;
  logic [SMP_W-1:0]  attack_q;
  logic [SMP_W-1:0]  release_q;
  logic              bypass_q;

  // limiter state
  longint                  envelope;
  int unsigned             wr_ptr;
  logic signed [SMP_W-1:0] hist_l [DEPTH];
  logic signed [SMP_W-1:0] hist_r [DEPTH];

  stereo_t pending_frames [$];

  function automatic longint clip_unity(input longint v);
    return (v > GAIN_ONE) ? GAIN_ONE : v;
  endfunction

  function automatic longint magnitude_of(input logic signed [SMP_W-1:0] s);
    longint v;
    v = longint'(s);
    return (v < 0) ? -v : v;
  endfunction

  // round half up, then clamp to the ceiling
  function automatic logic signed [SMP_W-1:0] scale_sample(
    input logic signed [SMP_W-1:0] s, input longint g, input longint c);
    longint q;
    q = (longint'(s) * g + ROUND_HALF) >>> FRAC;
    if (q > c) q = c;
    if (q < -c) q = -c;
    return q[SMP_W-1:0];
  endfunction

  // unless bypassed, advances the envelope and delay line by one frame; returns the output
  function automatic stereo_t limit_frame(input logic signed [SMP_W-1:0] l,
                                          input logic signed [SMP_W-1:0] r);
    longint  ceil_v;
    longint  peak;
    longint  target;
    longint  coef;
    longint  blend;
    int      rd;
    stereo_t res;
    if (bypass_q) begin
      res.left  = l;
      res.right = r;
      return res;
    end
    ceil_v = clip_unity(longint'(ceiling_q));
    peak   = magnitude_of(l);
    if (magnitude_of(r) > peak) peak = magnitude_of(r);
    target = (peak > ceil_v) ? (ceil_v << FRAC) / peak : GAIN_ONE;
    // blend uses the envelope before this frame
    coef     = clip_unity(longint'((target < envelope) ? attack_q : release_q));
    blend    = coef * envelope + (GAIN_ONE - coef) * target + ROUND_HALF;
    envelope = clip_unity(blend >>> FRAC);
    // write first so that zero lookahead reads the current frame
    hist_l[wr_ptr] = l;
    hist_r[wr_ptr] = r;
    rd = (wr_ptr + DEPTH - int'(look_q)) % DEPTH;
    res.left  = scale_sample(hist_l[rd], envelope, ceil_v);
    res.right = scale_sample(hist_r[rd], envelope, ceil_v);
    wr_ptr = (wr_ptr + 1) % DEPTH;
    return res;
  endfunction

  always @(posedge clk) begin
    logic signed [SMP_W-1:0] l_in;
    logic signed [SMP_W-1:0] r_in;
    stereo_t                 exp_frame;
    stereo_t                 got_frame;
    if (!rst_n) begin
      ceiling_q = UNITY;
      look_q    = '0;
      attack_q  = '0;
      release_q = 24'd8388000;
      bypass_q  = 1'b0;
      envelope  = GAIN_ONE;
      wr_ptr    = 0;
      foreach (hist_l[i]) begin
        hist_l[i] = '0;
        hist_r[i] = '0;
      end
      pending_frames.delete();
      mismatch_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_AW-1:2])
          REG_CEILING: ceiling_q = pwdata[SMP_W-1:0];
          REG_LOOK:    look_q    = pwdata[LOOK_W-1:0];
          REG_ATTACK:  attack_q  = pwdata[SMP_W-1:0];
          REG_RELEASE: release_q = pwdata[SMP_W-1:0];
          REG_BYPASS:  bypass_q  = pwdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        l_in = in_tdata[SMP_W-1:0];
        r_in = in_tuser ? l_in : in_tdata[2*SMP_W-1:SMP_W];
        pending_frames.push_back(limit_frame(l_in, r_in));
      end
      if (out_tvalid && out_tready) begin
        got_frame = out_tdata;
        if (pending_frames.size() == 0) begin
          $error("unexpected result: left_out %0d, right_out %0d",
                 got_frame.left, got_frame.right);
          mismatch_count++;
        end else begin
          exp_frame = pending_frames.pop_front();
          if (got_frame.left !== exp_frame.left) begin
            $error("left_out mismatch: expected %0d, got %0d",
                   exp_frame.left, got_frame.left);
            mismatch_count++;
          end
          if (got_frame.right !== exp_frame.right) begin
            $error("right_out mismatch: expected %0d, got %0d",
                   exp_frame.right, got_frame.right);
            mismatch_count++;
          end
        end
      end
    end
    frames_pending = pending_frames.size();
  end

endmodule

// ===== tb/lookahead_peak_limiter_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lookahead_peak_limiter_unit_tb
// Drives stereo and mono frames into the peak limiter under several register
// settings and flow-control patterns; the checker beside the block predicts
// and compares every result, this module only makes stimulus and the verdict.
// ---------------------------------------------------------------------------
module lookahead_peak_limiter_unit_tb;
  import lpl_pkg::*;

  localparam int          SETTLE_CYCLES = 40;
  localparam int          STALL_LIMIT   = 3000;  // cycles with no request moving
  localparam int          PHASES        = 8;
  localparam int          PHASE_FRAMES  = 50;
  localparam logic [2:0]  REG_UNUSED    = 3'd5;  // no register behind it
  localparam logic [23:0] POS_FULL      = 24'h7FFFFF;
  localparam logic [23:0] NEG_FULL      = 24'h800000;
  localparam logic [23:0] MINUS_ONE     = 24'hFFFFFF;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [47:0]       in_tdata;   // [23:0] left_in, [47:24] right_in
  logic              in_tuser;   // [0] mono_input
  logic              out_tvalid;
  logic              out_tready;
  logic [47:0]       out_tdata;  // [23:0] left_out, [47:24] right_out
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int unsigned mismatch_count;
  int unsigned frames_pending;
  int          send_idle_pct;    // chance per cycle that the sender holds off
  int          recv_stall_pct;   // chance per cycle that the receiver stalls
  int          quiet_cycles;

  lookahead_peak_limiter_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  lookahead_peak_limiter_unit_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .frames_pending (frames_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver side: a fresh stall decision every cycle
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog: any request on either stream restarts the count
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the request
  // is taken, with tvalid still high so back-to-back frames need no dip
  task automatic send_frame(input logic [23:0] l, input logic [23:0] r,
                            input logic mono);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r, l};
    in_tuser  <= mono;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // stop sending and wait out every outstanding result
  task automatic drain;
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (frames_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write: setup cycle then access cycle
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // levels for ceiling and coefficients, extremes and above-unity included
  function automatic logic [31:0] pick_level();
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return 32'(UNITY);
      2:       return $urandom_range(24'hFFFFFF, 32'(UNITY) + 1);
      default: return $urandom_range(32'(UNITY), 0);
    endcase
  endfunction

  // mix of full-range, quiet, near-clipping and corner samples
  function automatic logic [23:0] pick_sample();
    logic [23:0] mag;
    case ($urandom_range(7))
      0, 1, 2: return 24'($urandom());
      3: begin
        mag = 24'($urandom_range(4095));
        return $urandom_range(1) ? -mag : mag;
      end
      4, 5: begin
        mag = 24'($urandom_range(24'h7FFFFF, 24'h700000));
        return $urandom_range(1) ? -mag : mag;
      end
      default: begin
        case ($urandom_range(3))
          0:       return POS_FULL;
          1:       return NEG_FULL;
          2:       return MINUS_ONE;
          default: return 24'd0;
        endcase
      end
    endcase
  endfunction

  initial begin
    logic [8:0] look;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed part ---
    // reset settings: unity ceiling, no lookahead; full-scale peaks pass
    send_frame(24'd0, 24'd0, 1'b0);
    send_frame(POS_FULL, NEG_FULL, 1'b0);
    send_frame(NEG_FULL, 24'h123456, 1'b1);   // mono, right ignored
    send_frame(MINUS_ONE, 24'd1, 1'b0);
    drain();

    // half-scale ceiling with some lookahead: divider path and release
    write_reg(REG_CEILING, 32'h400000);
    write_reg(REG_LOOK,    32'd3);
    write_reg(REG_ATTACK,  32'h100000);
    write_reg(REG_RELEASE, 32'h7F0000);
    send_frame(POS_FULL, 24'd0, 1'b0);
    send_frame(24'd0, NEG_FULL, 1'b0);
    send_frame(24'h600000, 24'hA00000, 1'b0);
    send_frame(24'h000100, 24'hFFFF00, 1'b0);
    send_frame(24'h001234, 24'h001234, 1'b1);
    drain();

    // zero ceiling silences everything; the unused address must not land
    write_reg(REG_CEILING, 32'd0);
    write_reg(REG_UNUSED,  32'hFFFFFFFF);
    send_frame(24'd1, 24'd0, 1'b0);
    send_frame(24'd0, 24'd0, 1'b0);
    send_frame(NEG_FULL, POS_FULL, 1'b0);
    drain();

    // ceiling and coefficients above unity, longest lookahead (reads zeros)
    write_reg(REG_CEILING, 32'hFFFFFF);
    write_reg(REG_ATTACK,  32'hFFFFFF);
    write_reg(REG_RELEASE, 32'hFFFFFF);
    write_reg(REG_LOOK,    32'h1FF);
    send_frame(POS_FULL, NEG_FULL, 1'b0);
    send_frame(24'h400000, 24'hC00000, 1'b0);
    send_frame(24'hABCDEF, 24'd0, 1'b1);
    drain();

    // bypass: frames pass untouched, state frozen
    write_reg(REG_BYPASS, 32'd1);
    send_frame(NEG_FULL, POS_FULL, 1'b0);
    send_frame(POS_FULL, 24'h123456, 1'b1);
    send_frame(24'd0, MINUS_ONE, 1'b0);
    drain();

    // frozen attack (coefficient unity) and instant release toward a low ceiling
    write_reg(REG_BYPASS,  32'd0);
    write_reg(REG_LOOK,    32'd0);
    write_reg(REG_ATTACK,  32'(UNITY));
    write_reg(REG_RELEASE, 32'd0);
    write_reg(REG_CEILING, 32'h200000);
    send_frame(POS_FULL, 24'h100000, 1'b0);
    send_frame(24'h050000, 24'hFB0000, 1'b0);

    // --- random part: one register setting and flow pattern per phase ---
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      case ($urandom_range(3))
        0:       look = 9'd0;
        1:       look = 9'h1FF;
        2:       look = 9'($urandom_range(16, 1));
        default: look = 9'($urandom_range(511, 0));
      endcase
      write_reg(REG_CEILING, pick_level());
      write_reg(REG_LOOK,    32'(look));
      write_reg(REG_ATTACK,  pick_level());
      write_reg(REG_RELEASE, pick_level());
      write_reg(REG_BYPASS,  32'($urandom_range(7) == 0));
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        // sender holds off mid-stream until the pipeline is empty
        if (ph == 0 && n == PHASE_FRAMES / 2) drain();
        send_frame(pick_sample(), pick_sample(), $urandom_range(3) == 0);
      end
    end

    drain();
    if (mismatch_count == 0 && frames_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/lpl_pkg.sv
sv/lpl_div.sv
sv/lookahead_peak_limiter_unit.sv
tb/lookahead_peak_limiter_unit_checker.sv
tb/lookahead_peak_limiter_unit_tb.sv
